### hw/rtl/rtnb_pkg.sv
package rtnb_pkg;

   // Sizes of the code store and of the fields.
   localparam int MAX_LEAVES  = 1024;
   localparam int CODE_BITS   = 30;
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 11;
   localparam int OFF_W       = 12;
   localparam int POS_W       = 14;
   localparam int DELTA_W     = 8;
   localparam int PLEN_W      = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Input action codes.
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic                 is_query;
      logic [IDX_W-1:0]     index;
      logic [CODE_BITS-1:0] code;
   } item_type;

   // One finished node description.
   typedef struct packed {
      logic                 bad_query;
      logic [PLEN_W-1:0]    prefix_length;
      logic [CODE_BITS-1:0] prefix_code;
      logic [IDX_W-1:0]     range_end;
      logic                 right_is_leaf;
      logic [IDX_W-1:0]     right_child;
      logic                 left_is_leaf;
      logic [IDX_W-1:0]     left_child;
      logic [IDX_W-1:0]     node_number;
   } result_type;

endpackage

### hw/rtl/rtnb_front.sv
module rtnb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,
   input  logic               req_tuser,
   output logic               q_valid,
   output rtnb_pkg::item_type q_item,
   input  logic               q_pop
);

   rtnb_pkg::item_type                  queue_ff [rtnb_pkg::QUEUE_DEPTH];
   logic [rtnb_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [rtnb_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [rtnb_pkg::QCNT_W-1:0]         count_ff, count_in;
   rtnb_pkg::item_type                  item;
   logic                                push;
   logic                                pop;

   // Classify the incoming beat.
   always_comb begin
      item.is_query = (req_tuser == rtnb_pkg::ACTION_QUERY);
      item.index    = req_tdata[rtnb_pkg::IDX_W-1:0];
      item.code     = req_tdata[rtnb_pkg::IDX_W +: rtnb_pkg::CODE_BITS];
   end

   assign req_tready = (count_ff != rtnb_pkg::QCNT_W'(rtnb_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = queue_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### hw/rtl/rtnb_back.sv
module rtnb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rtnb_pkg::CNT_W-1:0]  leaf_count,
   input  logic                        q_valid,
   input  rtnb_pkg::item_type          q_item,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rtnb_pkg::result_type        rsp_result
);

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_PROBE, S_WAIT, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      K_DPLUS, K_DMINUS, K_EXP, K_BIN, K_DNODE, K_SPLIT
   } kind_type;

   localparam int CB = rtnb_pkg::CODE_BITS;
   localparam int IW = rtnb_pkg::IDX_W;
   localparam int OW = rtnb_pkg::OFF_W;
   localparam int PW = rtnb_pkg::POS_W;
   localparam int DW = rtnb_pkg::DELTA_W;
   localparam logic signed [DW-1:0] DELTA_NONE = -DW'(1);
   localparam logic signed [DW-1:0] DELTA_SELF = DW'(64);
   // Codes are compared as 32-bit words, indices as 32-bit words past the tie offset.
   localparam int CODE_LZ_BASE = 32 - CB;
   localparam int TIE_LZ_BASE  = 32 + 32 - IW;

   logic [CB-1:0]              mem [rtnb_pkg::MAX_LEAVES];
   logic [CB-1:0]              rd_ff;
   logic [IW-1:0]              rd_addr;
   logic                       mem_we;

   state_type                  state_ff, state_in;
   kind_type                   kind_ff, kind_in;
   logic [IW-1:0]              i_ff, i_in;
   logic [CB-1:0]              code_i_ff, code_i_in;
   logic [CB-1:0]              code_j_ff, code_j_in;
   logic [IW-1:0]              j_ff, j_in;
   logic                       neg_ff, neg_in;
   logic                       bad_ff, bad_in;
   logic signed [DW-1:0]       dp_ff, dp_in;
   logic signed [DW-1:0]       dmin_ff, dmin_in;
   logic signed [DW-1:0]       dnode_ff, dnode_in;
   logic [OW-1:0]              lmax_ff, lmax_in;
   logic [OW-1:0]              len_ff, len_in;
   logic [OW-1:0]              t_ff, t_in;
   logic [OW-1:0]              s_ff, s_in;
   logic signed [PW-1:0]       pos_ff, pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rtnb_pkg::result_type       result_ff, result_in;

   logic [rtnb_pkg::CNT_W-1:0] n_leaves;
   logic                       pos_ok;
   logic                       pos_self;
   logic signed [DW-1:0]       dval;
   logic                       gt_val;
   logic [OW-1:0]              sum_off;
   logic [OW-1:0]              t_next;
   logic                       out_free;
   logic signed [PW-1:0]       gamma;
   logic signed [PW-1:0]       gamma_p1;
   logic [IW-1:0]              lo_end;
   logic [IW-1:0]              hi_end;
   logic [CB-1:0]              diff;
   logic [CB-1:0]              keep;
   logic                       seen;

   // Leading zero count of a code-width word.
   function automatic logic [5:0] lz_code(input logic [CB-1:0] v);
      logic [5:0] n;
      n = 6'(CB);
      for (int k = 0; k < CB; k++) begin
         if (v[k]) begin
            n = 6'(CB - 1 - k);
         end
      end
      return n;
   endfunction

   // Leading zero count of an index-width word.
   function automatic logic [5:0] lz_idx(input logic [IW-1:0] v);
      logic [5:0] n;
      n = 6'(IW);
      for (int k = 0; k < IW; k++) begin
         if (v[k]) begin
            n = 6'(IW - 1 - k);
         end
      end
      return n;
   endfunction

   // Leaf position at a distance from the node, in the search direction.
   function automatic logic signed [PW-1:0] probe_pos(input logic [IW-1:0] i,
                                                      input logic neg,
                                                      input logic [OW-1:0] off);
      logic signed [PW-1:0] base;
      logic signed [PW-1:0] step;
      base = $signed(PW'(i));
      step = $signed(PW'(off));
      return neg ? base - step : base + step;
   endfunction

   assign n_leaves = (leaf_count > rtnb_pkg::CNT_W'(rtnb_pkg::MAX_LEAVES)) ?
                     rtnb_pkg::CNT_W'(rtnb_pkg::MAX_LEAVES) : leaf_count;
   assign pos_ok   = (pos_ff >= 0) && (pos_ff < $signed(PW'(n_leaves)));
   assign pos_self = (pos_ff == $signed(PW'(i_ff)));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign mem_we   = q_pop && !q_item.is_query;
   assign rd_addr  = (state_ff == S_IDLE) ? q_item.index : pos_ff[IW-1:0];

   // Code store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[q_item.index] <= q_item.code;
      end
      rd_ff <= mem[rd_addr];
   end

   // Prefix distance for the current probe.
   always_comb begin
      if (state_ff == S_WAIT) begin
         if ((code_i_ff ^ rd_ff) != '0) begin
            dval = $signed(DW'(CODE_LZ_BASE) + DW'(lz_code(code_i_ff ^ rd_ff)));
         end else begin
            dval = $signed(DW'(TIE_LZ_BASE) + DW'(lz_idx(i_ff ^ pos_ff[IW-1:0])));
         end
      end else begin
         dval = pos_self ? DELTA_SELF : DELTA_NONE;
      end
   end

   // Node range ends, split and common prefix of the finished search.
   always_comb begin
      gamma    = neg_ff ? $signed(PW'(i_ff)) - $signed(PW'(s_ff)) - PW'(1)
                        : $signed(PW'(i_ff)) + $signed(PW'(s_ff));
      gamma_p1 = gamma + PW'(1);
      lo_end   = (i_ff < j_ff) ? i_ff : j_ff;
      hi_end   = (i_ff > j_ff) ? i_ff : j_ff;
      diff     = code_i_ff ^ code_j_ff;
      seen     = 1'b0;
      for (int k = CB - 1; k >= 0; k--) begin
         seen    = seen | diff[k];
         keep[k] = !seen;
      end
   end

   // Search sequencer.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      i_in         = i_ff;
      code_i_in    = code_i_ff;
      code_j_in    = code_j_ff;
      j_in         = j_ff;
      neg_in       = neg_ff;
      bad_in       = bad_ff;
      dp_in        = dp_ff;
      dmin_in      = dmin_ff;
      dnode_in     = dnode_ff;
      lmax_in      = lmax_ff;
      len_in       = len_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;
      gt_val       = 1'b0;
      sum_off      = '0;
      t_next       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && q_item.is_query) begin
               i_in = q_item.index;
               if ((n_leaves < rtnb_pkg::CNT_W'(2)) ||
                   (rtnb_pkg::CNT_W'(q_item.index) >= n_leaves - 1'b1)) begin
                  bad_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  bad_in   = 1'b0;
                  state_in = S_START;
               end
            end
         end

         S_START: begin
            code_i_in = rd_ff;
            pos_in    = probe_pos(i_ff, 1'b0, OW'(1));
            kind_in   = K_DPLUS;
            state_in  = S_PROBE;
         end

         S_PROBE, S_WAIT: begin
            if ((state_ff == S_PROBE) && pos_ok && !pos_self) begin
               state_in = S_WAIT;
            end else begin
               state_in = S_PROBE;
               case (kind_ff)
                  K_DPLUS: begin
                     dp_in   = dval;
                     pos_in  = probe_pos(i_ff, 1'b1, OW'(1));
                     kind_in = K_DMINUS;
                  end
                  K_DMINUS: begin
                     neg_in  = !(dp_ff > dval);
                     dmin_in = (dp_ff > dval) ? dval : dp_ff;
                     lmax_in = OW'(2);
                     pos_in  = probe_pos(i_ff, !(dp_ff > dval), OW'(2));
                     kind_in = K_EXP;
                  end
                  K_EXP: begin
                     if (dval > dmin_ff) begin
                        lmax_in = lmax_ff << 1;
                        pos_in  = probe_pos(i_ff, neg_ff, lmax_ff << 1);
                     end else begin
                        len_in  = '0;
                        t_in    = lmax_ff >> 1;
                        pos_in  = probe_pos(i_ff, neg_ff, lmax_ff >> 1);
                        kind_in = K_BIN;
                     end
                  end
                  K_BIN: begin
                     gt_val  = (dval > dmin_ff);
                     sum_off = gt_val ? len_ff + t_ff : len_ff;
                     t_next  = t_ff >> 1;
                     len_in  = sum_off;
                     t_in    = t_next;
                     if (t_next != '0) begin
                        pos_in = probe_pos(i_ff, neg_ff, sum_off + t_next);
                     end else begin
                        pos_in  = probe_pos(i_ff, neg_ff, sum_off);
                        kind_in = K_DNODE;
                     end
                  end
                  K_DNODE: begin
                     dnode_in  = dval;
                     j_in      = pos_ff[IW-1:0];
                     code_j_in = pos_self ? code_i_ff : rd_ff;
                     s_in      = '0;
                     t_next    = OW'((len_ff + OW'(1)) >> 1);
                     t_in      = t_next;
                     pos_in    = probe_pos(i_ff, neg_ff, t_next);
                     kind_in   = K_SPLIT;
                     if (t_next == '0) begin
                        state_in = S_DONE;
                     end
                  end
                  K_SPLIT: begin
                     gt_val  = (dval > dnode_ff);
                     sum_off = gt_val ? s_ff + t_ff : s_ff;
                     t_next  = (t_ff == OW'(1)) ? '0 : OW'((t_ff + OW'(1)) >> 1);
                     s_in    = sum_off;
                     t_in    = t_next;
                     pos_in  = probe_pos(i_ff, neg_ff, sum_off + t_next);
                     if (t_next == '0) begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               result_in             = '0;
               result_in.node_number = i_ff;
               result_in.bad_query   = bad_ff;
               if (!bad_ff) begin
                  result_in.left_child    = gamma[IW-1:0];
                  result_in.left_is_leaf  = ($signed(PW'(lo_end)) == gamma);
                  result_in.right_child   = gamma_p1[IW-1:0];
                  result_in.right_is_leaf = ($signed(PW'(hi_end)) == gamma_p1);
                  result_in.range_end     = j_ff;
                  result_in.prefix_code   = code_i_ff & keep;
                  result_in.prefix_length = dnode_ff[rtnb_pkg::PLEN_W-1:0];
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_DPLUS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff      <= i_in;
      code_i_ff <= code_i_in;
      code_j_ff <= code_j_in;
      j_ff      <= j_in;
      neg_ff    <= neg_in;
      bad_ff    <= bad_in;
      dp_ff     <= dp_in;
      dmin_ff   <= dmin_in;
      dnode_ff  <= dnode_in;
      lmax_ff   <= lmax_in;
      len_ff    <= len_in;
      t_ff      <= t_in;
      s_ff      <= s_in;
      pos_ff    <= pos_in;
      result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

### hw/rtl/radix_tree_node_builder.sv
// Builds the nodes of a binary radix tree over sorted 30-bit Morton codes. A beat with
// tuser 0 loads a code into the 1024-entry store; a beat with tuser 1 asks for internal
// node i, and one response beat gives its children with leaf flags, the other end of its
// leaf range, the common prefix and its length (over 32 when equal codes were told apart
// by index). Loads give no response. Beats pass a four-deep queue and are then carried out
// one at a time in order. A query makes its code compares one after another, as the
// code store has a single read port. Write leaf_count only while the block is idle.
module radix_tree_node_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // index [9:0], code [39:10]
   input  logic [39:0] req_tdata,
   // action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // node_number [9:0], left_child [19:10], left_is_leaf [20], right_child [30:21],
   // right_is_leaf [31], range_end [41:32], prefix_code [71:42], prefix_length [78:72]
   output logic [79:0] rsp_tdata,
   // bad_query
   output logic        rsp_tuser
);

   logic [rtnb_pkg::CNT_W-1:0] leaf_count_ff;
   logic                       q_valid;
   logic                       q_pop;
   rtnb_pkg::item_type         q_item;
   rtnb_pkg::result_type       result;

   // Leaf count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= rtnb_pkg::CNT_W'(2);
      end else if (csr_we) begin
         leaf_count_ff <= csr_wdata;
      end
   end

   rtnb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   rtnb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .leaf_count (leaf_count_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Pack the response beat.
   assign rsp_tdata = {1'b0, result.prefix_length, result.prefix_code, result.range_end,
                       result.right_is_leaf, result.right_child, result.left_is_leaf,
                       result.left_child, result.node_number};
   assign rsp_tuser = result.bad_query;

endmodule

### tb/sv/tb_radix_tree_node_builder.sv
module tb_radix_tree_node_builder;
   import rtnb_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 400;
   localparam int RANDOM_BEATS = 1350;

   // Shadow of the block: code store, leaf count and the nodes still owed.
   class node_scoreboard;
      bit [31:0]  codes [MAX_LEAVES];
      int         leaves;
      result_type owed_nodes [$];
      int         mismatches;

      function new();
         leaves = 2;
         mismatches = 0;
      endfunction

      function int lead_zeros(bit [31:0] v);
         for (int k = 31; k >= 0; k--) begin
            if (v[k]) return 31 - k;
         end
         return 32;
      endfunction

      // Common prefix length of two leaves, with the index tie-break on equal codes.
      function int common_bits(int a, int b);
         bit [31:0] x;
         if (a < 0 || a >= leaves || b < 0 || b >= leaves) return -1;
         if (a == b) return 64;
         x = codes[a] ^ codes[b];
         if (x != 0) return lead_zeros(x);
         return 32 + lead_zeros(32'(a) ^ 32'(b));
      endfunction

      function result_type build_node(int idx);
         result_type r;
         int n, d, dmin, lmax, len, t, j, dnode, s, gamma, lo, hi, lz;
         bit [31:0] x, pre;
         r = '0;
         r.node_number = idx[IDX_W-1:0];
         n = (leaves > MAX_LEAVES) ? MAX_LEAVES : leaves;
         if (n < 2 || idx >= n - 1) begin
            r.bad_query = 1'b1;
            return r;
         end
         leaves = n;
         d = (common_bits(idx, idx + 1) - common_bits(idx, idx - 1) > 0) ? 1 : -1;
         dmin = common_bits(idx, idx - d);
         lmax = 2;
         while (common_bits(idx, idx + lmax * d) > dmin) lmax *= 2;
         len = 0;
         for (t = lmax / 2; t > 0; t /= 2) begin
            if (common_bits(idx, idx + (len + t) * d) > dmin) len += t;
         end
         j = idx + len * d;
         dnode = common_bits(idx, j);
         s = 0;
         t = (len + 1) / 2;
         while (t > 0) begin
            if (common_bits(idx, idx + (s + t) * d) > dnode) s += t;
            t = (t == 1) ? 0 : (t + 1) / 2;
         end
         gamma = idx + s * d + ((d < 0) ? -1 : 0);
         lo = (idx < j) ? idx : j;
         hi = (idx > j) ? idx : j;
         // Keep only the bits that both end codes share.
         x = codes[idx] ^ codes[j];
         if (x == 0) begin
            pre = codes[idx];
         end else begin
            lz = lead_zeros(x);
            pre = (lz == 0) ? 32'd0 : (codes[idx] & (32'hFFFF_FFFF << (32 - lz)));
         end
         r.left_child    = gamma[IDX_W-1:0];
         r.left_is_leaf  = (lo == gamma);
         r.right_child   = 10'(gamma + 1);
         r.right_is_leaf = (hi == gamma + 1);
         r.range_end     = j[IDX_W-1:0];
         r.prefix_code   = pre[CODE_BITS-1:0];
         r.prefix_length = dnode[PLEN_W-1:0];
         return r;
      endfunction

      // Note an accepted request beat.
      function void note_request(bit action, bit [9:0] idx, bit [29:0] code);
         int saved;
         if (action == ACTION_LOAD) begin
            codes[idx] = {2'b00, code};
         end else begin
            saved = leaves;
            owed_nodes.push_back(build_node(idx));
            leaves = saved;
         end
      endfunction

      function void field(string name, longint exp_v, longint got_v);
         if (exp_v != got_v) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch %s: expected %0d actual %0d", name, exp_v, got_v);
         end
      endfunction

      // Compare a response beat against the oldest owed node.
      function void check_response(bit [79:0] data, bit user);
         result_type e, g;
         g = result_type'({user, data[78:0]});
         if (owed_nodes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat node %0d", g.node_number);
            return;
         end
         e = owed_nodes.pop_front();
         field("node_number", e.node_number, g.node_number);
         field("left_child", e.left_child, g.left_child);
         field("left_is_leaf", e.left_is_leaf, g.left_is_leaf);
         field("right_child", e.right_child, g.right_child);
         field("right_is_leaf", e.right_is_leaf, g.right_is_leaf);
         field("range_end", e.range_end, g.range_end);
         field("prefix_code", e.prefix_code, g.prefix_code);
         field("prefix_length", e.prefix_length, g.prefix_length);
         field("bad_query", e.bad_query, g.bad_query);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;

   node_scoreboard sb = new();
   bit  calm = 1'b0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   int  random_beats = 0;
   bit [29:0] sorted_codes [$];

   radix_tree_node_builder uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response side: check accepted beats and stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Send one request beat and wait for its handshake.
   task automatic send_beat(bit action, bit [9:0] idx, bit [29:0] code);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {code, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(action, idx, code);
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait for the block to drain, then write the leaf count.
   task automatic set_leaves(int n);
      req_tvalid <= 1'b0;
      while (sb.owed_nodes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= 11'(n);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.leaves = n;
   endtask

   // Load positions 0..n-1 with sorted codes, some repeated, sometimes unsorted.
   task automatic load_set(int n);
      bit [29:0] base, low_mask;
      int width;
      width = $urandom_range(0, 30);
      low_mask = (width == 30) ? 30'h3FFF_FFFF : 30'((1 << width) - 1);
      base = 30'($urandom());
      sorted_codes.delete();
      for (int k = 0; k < n; k++)
         sorted_codes.push_back((base & ~low_mask) | (30'($urandom()) & low_mask));
      if ($urandom_range(0, 9) != 0) sorted_codes.sort();
      for (int k = 1; k < n; k++)
         if ($urandom_range(0, 3) == 0) sorted_codes[k] = sorted_codes[k-1];
      for (int k = 0; k < n; k++) begin
         send_beat(ACTION_LOAD, 10'(k), sorted_codes[k]);
         random_beats++;
      end
   endtask

   task automatic query_mix(int n, int count);
      int roll;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            send_beat(ACTION_LOAD, 10'($urandom_range(0, 1023)), 30'($urandom()));
         else if (roll < 14)
            send_beat(ACTION_QUERY, 10'($urandom_range(0, 1023)), 30'($urandom()));
         else
            send_beat(ACTION_QUERY, 10'($urandom_range(0, n - 2)), 30'($urandom()));
         random_beats++;
      end
   endtask

   initial begin
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of codes, bad queries, tiny leaf counts and equal codes.
      send_beat(ACTION_LOAD, 10'd0, 30'd0);
      send_beat(ACTION_LOAD, 10'd1, 30'h3FFF_FFFF);
      send_beat(ACTION_QUERY, 10'd0, 30'h3FFF_FFFF);
      send_beat(ACTION_QUERY, 10'd1, 30'd0);
      send_beat(ACTION_QUERY, 10'd1023, 30'd0);
      set_leaves(0);
      send_beat(ACTION_QUERY, 10'd0, 30'd0);
      set_leaves(1);
      send_beat(ACTION_QUERY, 10'd0, 30'd0);
      set_leaves(2);
      send_beat(ACTION_LOAD, 10'd1, 30'd0);
      send_beat(ACTION_QUERY, 10'd0, 30'd0);
      send_beat(ACTION_LOAD, 10'd2, 30'h2AAA_AAAA);
      set_leaves(3);
      send_beat(ACTION_QUERY, 10'd0, 30'd0);
      send_beat(ACTION_QUERY, 10'd1, 30'd0);

      // Full store once, then a leaf count above the store size.
      set_leaves(1024);
      load_set(1024);
      send_beat(ACTION_QUERY, 10'd1022, 30'd0);
      send_beat(ACTION_QUERY, 10'd0, 30'd0);
      query_mix(1024, 30);
      set_leaves(2047);
      send_beat(ACTION_QUERY, 10'd1022, 30'd0);
      send_beat(ACTION_QUERY, 10'd1023, 30'd0);
      query_mix(1024, 10);

      // Random phases, mostly small sets, sized to stay near the beat budget.
      while (random_beats < RANDOM_BEATS) begin
         n = $urandom_range(0, 9);
         n = (n < 7) ? $urandom_range(2, 40) : (n < 9) ? $urandom_range(41, 300)
                                                         : $urandom_range(301, 1024);
         if (n > RANDOM_BEATS - random_beats)
            n = (RANDOM_BEATS - random_beats > 2) ? RANDOM_BEATS - random_beats : 2;
         if (random_beats > RANDOM_BEATS - 150) calm = 1'b1;
         set_leaves(n);
         load_set(n);
         query_mix(n, $urandom_range(10, 40));
      end

      req_tvalid <= 1'b0;
      while (sb.owed_nodes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed_nodes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
